[hw/rtl/command_line_lexer_core_assert.svh]
// Assertion macros shared by the command line lexer RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef COMMAND_LINE_LEXER_CORE_ASSERT_SVH
`define COMMAND_LINE_LEXER_CORE_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define CLL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that an expression never holds outside reset.
`define CLL_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

[hw/rtl/cll_pkg.sv]
// Shared types, constants and keyword table for the command line lexer.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package cll_pkg;

  // Line store and keyword sizes
  localparam int LINE_LENGTH = 1024;
  localparam int POS_W       = $clog2(LINE_LENGTH) + 1;
  localparam int FIELD_POS_W = 10;
  localparam int KEYWORD_MAX = 18;
  localparam int KW_LEN_W    = $clog2(KEYWORD_MAX + 1);
  localparam int NUM_KW      = 11;
  localparam int CMD_W       = 4;
  localparam int REPLY_W     = 3;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [POS_W-1:0]       posw_t;
  typedef logic [FIELD_POS_W-1:0] pos_t;
  typedef logic [KW_LEN_W-1:0]    kwlen_t;
  typedef logic [CMD_W-1:0]       cmd_t;
  typedef logic [REPLY_W-1:0]     reply_t;
  typedef logic [Q_CNT_W-1:0]     qcnt_t;

  localparam posw_t  LINE_END   = posw_t'(LINE_LENGTH);
  localparam kwlen_t KW_SAT     = kwlen_t'(KEYWORD_MAX);
  localparam qcnt_t  Q_FULL     = qcnt_t'(Q_DEPTH);

  // Command codes
  localparam cmd_t OP_NONE      = cmd_t'(0);
  localparam cmd_t OP_HELP      = cmd_t'(1);
  localparam cmd_t OP_PING      = cmd_t'(2);
  localparam cmd_t OP_REGISTER  = cmd_t'(3);
  localparam cmd_t OP_LOGIN     = cmd_t'(4);

  // Reply codes
  localparam reply_t RPL_PONG         = reply_t'(0);
  localparam reply_t RPL_HELP         = reply_t'(1);
  localparam reply_t RPL_DO_REGISTER  = reply_t'(2);
  localparam reply_t RPL_REG_USAGE    = reply_t'(3);
  localparam reply_t RPL_DO_LOGIN     = reply_t'(4);
  localparam reply_t RPL_LOGIN_USAGE  = reply_t'(5);
  localparam reply_t RPL_UNKNOWN      = reply_t'(6);

  // Keywords, right-justified: the first character sits in the highest used byte
  localparam logic [KEYWORD_MAX*8-1:0] KW_TEXT [NUM_KW] = '{
    "HELP", "PING", "REGISTER", "LOGIN", {"CREATE", "_PROJECT"}, {"INVITE", "_MEMBER"},
    {"CREATE", "_TASK"}, "UPDATE_TASK_STATUS", {"ADD", "_COMMENT"}, {"GET", "_GANTT"},
    "CHAT"
  };

  localparam kwlen_t KW_LEN [NUM_KW] = '{
    kwlen_t'(4), kwlen_t'(4), kwlen_t'(8), kwlen_t'(5), kwlen_t'(14), kwlen_t'(13),
    kwlen_t'(11), kwlen_t'(18), kwlen_t'(11), kwlen_t'(9), kwlen_t'(4)
  };

  // One classified byte on its way from front to back
  typedef struct packed {
    logic [7:0] ch_up;
    logic       space;
    logic       last;
  } item_t;

  // One line result
  typedef struct packed {
    cmd_t   command_code;
    logic   has_arg1;
    pos_t   arg1_pos;
    logic   has_arg2;
    pos_t   arg2_pos;
    logic   has_arg3;
    pos_t   arg3_pos;
    logic   has_rest;
    pos_t   rest_pos;
    reply_t reply_code;
    logic   too_long;
  } res_t;

  // True when keyword k has upper-case character u at index idx
  function automatic logic kw_hit(input int k, input kwlen_t idx, input logic [7:0] u);
    kwlen_t p;
    if (idx >= KW_LEN[k]) return 1'b0;
    p = KW_LEN[k] - idx - kwlen_t'(1);
    return KW_TEXT[k][8*p +: 8] == u;
  endfunction

endpackage

[hw/rtl/cll_front.sv]
// Front stage of the command line lexer: accept bytes, classify and fold case.
// Depends on cll_pkg.
`timescale 1ns / 1ps

module cll_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_char_byte,
  input  logic           in_last,
  output logic           push_valid,
  input  logic           push_ready,
  output cll_pkg::item_t push_item
);

  logic           stg_valid_r;
  cll_pkg::item_t stg_item_r;
  cll_pkg::item_t cls_item;

  // Whitespace is 9..13 and 32; fold only a..z
  always_comb begin
    cls_item.space = in_char_byte inside {[8'd9:8'd13], 8'd32};
    cls_item.ch_up = (in_char_byte inside {[8'd97:8'd122]}) ? (in_char_byte - 8'd32)
                                                             : in_char_byte;
    cls_item.last  = in_last;
  end

  assign in_ready   = !stg_valid_r || push_ready;
  assign push_valid = stg_valid_r;
  assign push_item  = stg_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_item_r <= cls_item;
    end
  end

endmodule

[hw/rtl/cll_queue.sv]
// Short FIFO of classified bytes between front and back.
// Depends on cll_pkg and command_line_lexer_core_assert.svh.
`timescale 1ns / 1ps
`include "command_line_lexer_core_assert.svh"

module cll_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  cll_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cll_pkg::item_t pop_item
);

  cll_pkg::item_t                mem [cll_pkg::Q_DEPTH];
  logic [cll_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [cll_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  cll_pkg::qcnt_t                cnt_r;
  logic                          push;
  logic                          pop;
  logic                          q_empty;
  logic                          q_full;

  assign q_empty    = cnt_r == '0;
  assign q_full     = cnt_r == cll_pkg::Q_FULL;
  assign push_ready = !q_full;
  assign pop_valid  = !q_empty;
  assign pop_item   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `CLL_ASSERT(a_q_cnt_bound, cnt_r <= cll_pkg::Q_FULL, "queue count above depth")
  `CLL_ASSERT(a_q_ptr_gap, q_empty || q_full || (wr_ptr_r != rd_ptr_r), "queue pointers off")
  `CLL_ASSERT_NEVER(a_q_pop_empty, pop && q_empty, "pop from an empty queue")

endmodule

[hw/rtl/cll_back.sv]
// Back stage of the command line lexer: token tracking, keyword match, result register.
// Depends on cll_pkg and command_line_lexer_core_assert.svh.
`timescale 1ns / 1ps
`include "command_line_lexer_core_assert.svh"

module cll_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  cll_pkg::item_t pop_item,
  output logic           out_valid,
  input  logic           out_ready,
  output cll_pkg::res_t  out_res
);

  localparam logic [2:0] TC_ONE   = 3'd1;
  localparam logic [2:0] TC_TWO   = 3'd2;
  localparam logic [2:0] TC_THREE = 3'd3;
  localparam logic [2:0] TC_FOUR  = 3'd4;
  localparam logic [2:0] TC_SAT   = 3'd5;

  cll_pkg::posw_t              pos_r,    pos_nxt;
  logic [2:0]                  tc_r,     tc_nxt;
  logic                        in_tok_r, in_tok_nxt;
  logic [cll_pkg::NUM_KW-1:0]  alive_r,  alive_nxt;
  cll_pkg::kwlen_t             ftl_r,    ftl_nxt;
  cll_pkg::pos_t               arg_r [3];
  cll_pkg::pos_t               arg_nxt [3];
  cll_pkg::pos_t               rest_r,   rest_nxt;
  logic [3:0]                  found_r,  found_nxt;
  logic                        ovf_r,    ovf_nxt;
  logic                        out_valid_r;
  cll_pkg::res_t               res_r,    res_nxt;

  cll_pkg::posw_t              off_full;
  cll_pkg::pos_t               off;
  cll_pkg::cmd_t               code;
  logic                        two_args;
  logic                        pop;

  logic                        res_is_pong;
  logic                        res_is_ping;
  logic                        res_args_full;

  // Stall only a line end, and only while the result register is still full
  assign pop_ready = !pop_item.last || !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    pos_nxt    = pos_r;
    tc_nxt     = tc_r;
    in_tok_nxt = in_tok_r;
    alive_nxt  = alive_r;
    ftl_nxt    = ftl_r;
    arg_nxt    = arg_r;
    rest_nxt   = rest_r;
    found_nxt  = found_r;
    ovf_nxt    = ovf_r;

    off_full = (pos_r >= cll_pkg::LINE_END) ? (cll_pkg::LINE_END - 1'b1) : pos_r;
    off      = cll_pkg::pos_t'(off_full);
    if (pos_r >= cll_pkg::LINE_END) ovf_nxt = 1'b1;

    if (pop_item.space) begin
      in_tok_nxt = 1'b0;
    end else begin
      if (!in_tok_r) begin
        in_tok_nxt = 1'b1;
        case (tc_r)
          TC_ONE: begin
            arg_nxt[0]   = off;
            found_nxt[0] = 1'b1;
          end
          TC_TWO: begin
            arg_nxt[1]   = off;
            found_nxt[1] = 1'b1;
          end
          TC_THREE: begin
            arg_nxt[2]   = off;
            found_nxt[2] = 1'b1;
          end
          TC_FOUR: begin
            rest_nxt     = off;
            found_nxt[3] = 1'b1;
          end
          default: ;
        endcase
        if (tc_r < TC_SAT) tc_nxt = tc_r + 3'd1;
      end
      // Drop keywords that disagree with this byte of the first token
      if (tc_nxt == TC_ONE) begin
        for (int k = 0; k < cll_pkg::NUM_KW; k++) begin
          if (!cll_pkg::kw_hit(k, ftl_r, pop_item.ch_up)) alive_nxt[k] = 1'b0;
        end
        if (ftl_r < cll_pkg::KW_SAT) ftl_nxt = ftl_r + 1'b1;
      end
    end

    if (pos_r < cll_pkg::LINE_END) pos_nxt = pos_r + 1'b1;

    // Lowest numbered surviving keyword of exact length wins
    code = cll_pkg::OP_NONE;
    for (int k = cll_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (tc_nxt != 3'd0 && alive_nxt[k] && cll_pkg::KW_LEN[k] == ftl_nxt) begin
        code = cll_pkg::cmd_t'(k + 1);
      end
    end

    two_args = found_nxt[1:0] == 2'b11;
    res_nxt.command_code = code;
    case (code)
      cll_pkg::OP_PING:     res_nxt.reply_code = cll_pkg::RPL_PONG;
      cll_pkg::OP_HELP:     res_nxt.reply_code = cll_pkg::RPL_HELP;
      cll_pkg::OP_REGISTER: res_nxt.reply_code = two_args ? cll_pkg::RPL_DO_REGISTER
                                                          : cll_pkg::RPL_REG_USAGE;
      cll_pkg::OP_LOGIN:    res_nxt.reply_code = two_args ? cll_pkg::RPL_DO_LOGIN
                                                          : cll_pkg::RPL_LOGIN_USAGE;
      default:              res_nxt.reply_code = cll_pkg::RPL_UNKNOWN;
    endcase
    res_nxt.has_arg1 = found_nxt[0];
    res_nxt.arg1_pos = found_nxt[0] ? arg_nxt[0] : '0;
    res_nxt.has_arg2 = found_nxt[1];
    res_nxt.arg2_pos = found_nxt[1] ? arg_nxt[1] : '0;
    res_nxt.has_arg3 = found_nxt[2];
    res_nxt.arg3_pos = found_nxt[2] ? arg_nxt[2] : '0;
    res_nxt.has_rest = found_nxt[3];
    res_nxt.rest_pos = found_nxt[3] ? rest_nxt : '0;
    res_nxt.too_long = ovf_nxt;
  end

  // Lexer state: restart after every line end
  always_ff @(posedge clk) begin
    if (!rst_n || (pop && pop_item.last)) begin
      pos_r    <= '0;
      tc_r     <= '0;
      in_tok_r <= 1'b0;
      alive_r  <= '1;
      ftl_r    <= '0;
      arg_r    <= '{default: '0};
      rest_r   <= '0;
      found_r  <= '0;
      ovf_r    <= 1'b0;
    end else if (pop) begin
      pos_r    <= pos_nxt;
      tc_r     <= tc_nxt;
      in_tok_r <= in_tok_nxt;
      alive_r  <= alive_nxt;
      ftl_r    <= ftl_nxt;
      arg_r    <= arg_nxt;
      rest_r   <= rest_nxt;
      found_r  <= found_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && pop_item.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_item.last) begin
      res_r <= res_nxt;
    end
  end

  assign res_is_pong   = res_r.reply_code == cll_pkg::RPL_PONG;
  assign res_is_ping   = res_r.command_code == cll_pkg::OP_PING;
  assign res_args_full = res_r.has_arg1 && res_r.has_arg2 && res_r.has_arg3;

  `CLL_ASSERT(a_ping_pong, out_valid_r |-> (res_is_pong == res_is_ping), "pong without ping")
  `CLL_ASSERT(a_rest_args, (out_valid_r && res_r.has_rest) |-> res_args_full, "rest without args")
  `CLL_ASSERT_NEVER(a_tc_range, tc_r > TC_SAT, "token count beyond saturation")

endmodule

[hw/rtl/command_line_lexer_core.sv]
// Top level of the command line lexer: front classifier, byte queue, back lexer.
// Depends on cll_pkg, cll_front, cll_queue and cll_back.
`timescale 1ns / 1ps
//
//  Channel | Ports                                   | Direction | Moves
//  --------+-----------------------------------------+-----------+-------------------------
//  in      | in_valid, in_ready, in_char_byte,       | sink      | one byte of a line
//          | in_last                                 |           | per transaction
//  out     | out_valid, out_ready, out_command_code, | source    | one line result
//          | out_has_arg*/out_arg*_pos, out_has_rest,|           | per transaction
//          | out_rest_pos, out_reply_code,           |           |
//          | out_too_long                            |           |
//
//  Throughput: one byte per cycle when not stalled; one back-lexer state update per byte.
//  Path: the last byte of a line goes from the front register into a queue slot, then into
//  the result register, which raises out_valid.
//  Reset: rst_n is synchronous, active low; it empties queue and result register.
//  Stalls: the back waits only when a line end meets a full result register; the queue
//  and front register absorb later bytes until they fill, then in_ready drops.

module command_line_lexer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input byte channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_char_byte,
  input  logic                        in_last,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cll_pkg::CMD_W-1:0]   out_command_code,
  output logic                        out_has_arg1,
  output logic [9:0]                  out_arg1_pos,
  output logic                        out_has_arg2,
  output logic [9:0]                  out_arg2_pos,
  output logic                        out_has_arg3,
  output logic [9:0]                  out_arg3_pos,
  output logic                        out_has_rest,
  output logic [9:0]                  out_rest_pos,
  output logic [cll_pkg::REPLY_W-1:0] out_reply_code,
  output logic                        out_too_long
);

  // Front to queue
  logic           push_valid;
  logic           push_ready;
  cll_pkg::item_t push_item;

  // Queue to back
  logic           pop_valid;
  logic           pop_ready;
  cll_pkg::item_t pop_item;

  // Registered line result
  cll_pkg::res_t  res;

  // Classify each byte (whitespace flag, upper-case fold) and hold it until the queue takes it
  cll_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .in_last      (in_last),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  // Decouple the front from result stalls at the back
  cll_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Track tokens, narrow the keyword set and register the result at each line end
  cll_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Unpack the result register onto the field ports
  assign out_command_code = res.command_code;
  assign out_has_arg1     = res.has_arg1;
  assign out_arg1_pos     = res.arg1_pos;
  assign out_has_arg2     = res.has_arg2;
  assign out_arg2_pos     = res.arg2_pos;
  assign out_has_arg3     = res.has_arg3;
  assign out_arg3_pos     = res.arg3_pos;
  assign out_has_rest     = res.has_rest;
  assign out_rest_pos     = res.rest_pos;
  assign out_reply_code   = res.reply_code;
  assign out_too_long     = res.too_long;

endmodule

[verif/cll_checker.sv]
// Line-result checker for the command line lexer testbench.
// Depends on cll_pkg for the result struct and the command and reply codes.
`timescale 1ns / 1ps

module cll_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  in_char_byte,
  input  logic                        in_last,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [cll_pkg::CMD_W-1:0]   out_command_code,
  input  logic                        out_has_arg1,
  input  logic [9:0]                  out_arg1_pos,
  input  logic                        out_has_arg2,
  input  logic [9:0]                  out_arg2_pos,
  input  logic                        out_has_arg3,
  input  logic [9:0]                  out_arg3_pos,
  input  logic                        out_has_rest,
  input  logic [9:0]                  out_rest_pos,
  input  logic [cll_pkg::REPLY_W-1:0] out_reply_code,
  input  logic                        out_too_long,
  output int                          lines_pending,
  output int                          error_count
);

  localparam int LINE_BYTES = cll_pkg::LINE_LENGTH;
  localparam int NAME_MAX   = cll_pkg::KEYWORD_MAX;
  localparam int NUM_NAMES  = cll_pkg::NUM_KW;

  cll_pkg::res_t  expected_lines[$];

  // Per-line lexing state
  cll_pkg::posw_t line_pos;
  int             tokens_seen;
  logic           in_word;
  logic [7:0]     word_text [NAME_MAX];
  int             word_len;       // NAME_MAX + 1 marks a first word too long to match
  cll_pkg::pos_t  arg_pos [3];
  cll_pkg::pos_t  rest_at;
  logic [3:0]     found;
  logic           overflow;

  initial begin
    lines_pending = 0;
    error_count   = 0;
  end

  function automatic string command_word(input int code);
    case (code)
      1:       return "HELP";
      2:       return "PING";
      3:       return "REGISTER";
      4:       return "LOGIN";
      5:       return {"CREATE", "_PROJECT"};
      6:       return {"INVITE", "_MEMBER"};
      7:       return {"CREATE", "_TASK"};
      8:       return "UPDATE_TASK_STATUS";
      9:       return {"ADD", "_COMMENT"};
      10:      return {"GET", "_GANTT"};
      11:      return "CHAT";
      default: return "";
    endcase
  endfunction

  // Exact, full-length match of the folded first word against the command names.
  function automatic cll_pkg::cmd_t lookup_command();
    string kw;
    logic  same;
    for (int code = 1; code <= NUM_NAMES; code++) begin
      kw = command_word(code);
      if (kw.len() == word_len) begin
        same = 1'b1;
        for (int i = 0; i < word_len; i++)
          if (word_text[i] != kw[i]) same = 1'b0;
        if (same) return cll_pkg::cmd_t'(code);
      end
    end
    return cll_pkg::OP_NONE;
  endfunction

  task automatic clear_line();
    line_pos    = '0;
    tokens_seen = 0;
    in_word     = 1'b0;
    word_len    = 0;
    arg_pos[0]  = '0;
    arg_pos[1]  = '0;
    arg_pos[2]  = '0;
    rest_at     = '0;
    found       = '0;
    overflow    = 1'b0;
  endtask

  task automatic take_byte(input logic [7:0] c, input logic fin);
    cll_pkg::pos_t  off;
    cll_pkg::res_t  r;
    logic           blank;
    logic           both_args;
    blank = (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    if (line_pos >= cll_pkg::posw_t'(LINE_BYTES)) begin
      overflow = 1'b1;
      off      = cll_pkg::pos_t'(LINE_BYTES - 1);
    end else begin
      off = line_pos[9:0];
    end
    if (!blank) begin
      if (!in_word) begin
        in_word = 1'b1;
        if (tokens_seen >= 1 && tokens_seen <= 3) begin
          arg_pos[tokens_seen-1] = off;
          found[tokens_seen-1]   = 1'b1;
        end else if (tokens_seen == 4) begin
          rest_at  = off;
          found[3] = 1'b1;
        end
        if (tokens_seen < 5) tokens_seen++;
      end
      if (tokens_seen == 1) begin
        // fold a..z only
        if (word_len < NAME_MAX)
          word_text[word_len] = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
        if (word_len <= NAME_MAX) word_len++;
      end
    end else begin
      in_word = 1'b0;
    end
    if (line_pos < cll_pkg::posw_t'(LINE_BYTES)) line_pos++;

    if (fin) begin
      r.command_code = lookup_command();
      r.has_arg1     = found[0];
      r.arg1_pos     = found[0] ? arg_pos[0] : '0;
      r.has_arg2     = found[1];
      r.arg2_pos     = found[1] ? arg_pos[1] : '0;
      r.has_arg3     = found[2];
      r.arg3_pos     = found[2] ? arg_pos[2] : '0;
      r.has_rest     = found[3];
      r.rest_pos     = found[3] ? rest_at : '0;
      r.too_long     = overflow;
      both_args      = found[0] && found[1];
      case (r.command_code)
        cll_pkg::OP_PING:     r.reply_code = cll_pkg::RPL_PONG;
        cll_pkg::OP_HELP:     r.reply_code = cll_pkg::RPL_HELP;
        cll_pkg::OP_REGISTER: r.reply_code = both_args ? cll_pkg::RPL_DO_REGISTER
                                                       : cll_pkg::RPL_REG_USAGE;
        cll_pkg::OP_LOGIN:    r.reply_code = both_args ? cll_pkg::RPL_DO_LOGIN
                                                       : cll_pkg::RPL_LOGIN_USAGE;
        default:              r.reply_code = cll_pkg::RPL_UNKNOWN;
      endcase
      expected_lines.push_back(r);
      clear_line();
    end
  endtask

  task automatic check_result();
    cll_pkg::res_t got;
    cll_pkg::res_t want;
    got.command_code = out_command_code;
    got.has_arg1     = out_has_arg1;
    got.arg1_pos     = out_arg1_pos;
    got.has_arg2     = out_has_arg2;
    got.arg2_pos     = out_arg2_pos;
    got.has_arg3     = out_has_arg3;
    got.arg3_pos     = out_arg3_pos;
    got.has_rest     = out_has_rest;
    got.rest_pos     = out_rest_pos;
    got.reply_code   = out_reply_code;
    got.too_long     = out_too_long;
    if (expected_lines.size() == 0) begin
      if (error_count < 10)
        $display("%0t: line result with no line pending: cmd=%0d reply=%0d",
                 $realtime, got.command_code, got.reply_code);
      error_count <= error_count + 1;
      return;
    end
    want = expected_lines.pop_front();
    if (got !== want) begin
      if (error_count < 10) begin
        $display("%0t: line result mismatch", $realtime);
        $display("  expected cmd=%0d flags=%b%b%b%b pos=%0d/%0d/%0d/%0d reply=%0d long=%b",
                 want.command_code, want.has_arg1, want.has_arg2, want.has_arg3,
                 want.has_rest, want.arg1_pos, want.arg2_pos, want.arg3_pos,
                 want.rest_pos, want.reply_code, want.too_long);
        $display("  actual   cmd=%0d flags=%b%b%b%b pos=%0d/%0d/%0d/%0d reply=%0d long=%b",
                 got.command_code, got.has_arg1, got.has_arg2, got.has_arg3,
                 got.has_rest, got.arg1_pos, got.arg2_pos, got.arg3_pos,
                 got.rest_pos, got.reply_code, got.too_long);
      end
      error_count <= error_count + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_lines.delete();
      clear_line();
      lines_pending <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) take_byte(in_char_byte, in_last);
      lines_pending <= expected_lines.size();
    end
  end

endmodule

[verif/tb_command_line_lexer_core.sv]
// Testbench top for command_line_lexer_core: clock, reset, byte-line stimulus, verdict.
// Depends on cll_pkg, the block under test and cll_checker, which predicts and compares.
`timescale 1ns / 1ps

module tb_command_line_lexer_core;

  // Idling phases: which side may insert gaps, and how often
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // Random part of the run; the directed lines add roughly another 230 bytes
  localparam int RANDOM_BYTES = 720;
  localparam int DRAIN_LIMIT  = 20000;

  logic                        clk;
  logic                        rst_n        = 1'b0;
  logic                        in_valid     = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_char_byte = 8'h00;
  logic                        in_last      = 1'b0;
  logic                        out_valid;
  logic                        out_ready    = 1'b0;
  logic [cll_pkg::CMD_W-1:0]   out_command_code;
  logic                        out_has_arg1;
  logic [9:0]                  out_arg1_pos;
  logic                        out_has_arg2;
  logic [9:0]                  out_arg2_pos;
  logic                        out_has_arg3;
  logic [9:0]                  out_arg3_pos;
  logic                        out_has_rest;
  logic [9:0]                  out_rest_pos;
  logic [cll_pkg::REPLY_W-1:0] out_reply_code;
  logic                        out_too_long;

  int          lines_pending;
  int          error_count;
  idle_mode_t  idle_mode = IDLE_NONE;
  logic [7:0]  line_buf[$];

  command_line_lexer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_code (out_command_code),
    .out_has_arg1     (out_has_arg1),
    .out_arg1_pos     (out_arg1_pos),
    .out_has_arg2     (out_has_arg2),
    .out_arg2_pos     (out_arg2_pos),
    .out_has_arg3     (out_has_arg3),
    .out_arg3_pos     (out_arg3_pos),
    .out_has_rest     (out_has_rest),
    .out_rest_pos     (out_rest_pos),
    .out_reply_code   (out_reply_code),
    .out_too_long     (out_too_long)
  );

  // The checker sits on both channels; it keeps the expected line results and
  // hands back how many are still owed and how many went wrong.
  cll_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_code (out_command_code),
    .out_has_arg1     (out_has_arg1),
    .out_arg1_pos     (out_arg1_pos),
    .out_has_arg2     (out_has_arg2),
    .out_arg2_pos     (out_arg2_pos),
    .out_has_arg3     (out_has_arg3),
    .out_arg3_pos     (out_arg3_pos),
    .out_has_rest     (out_has_rest),
    .out_rest_pos     (out_rest_pos),
    .out_reply_code   (out_reply_code),
    .out_too_long     (out_too_long),
    .lines_pending    (lines_pending),
    .error_count      (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: stall at random according to the current phase.
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_ready <= ($urandom_range(0, 99) >= 62);
      IDLE_BOTH:     out_ready <= ($urandom_range(0, 99) >= 7);
      default:       out_ready <= 1'b1;
    endcase
  end

  function automatic string keyword_text(input int k);
    case (k)
      0:       return "HELP";
      1:       return "PING";
      2:       return "REGISTER";
      3:       return "LOGIN";
      4:       return {"CREATE", "_PROJECT"};
      5:       return {"INVITE", "_MEMBER"};
      6:       return {"CREATE", "_TASK"};
      7:       return "UPDATE_TASK_STATUS";
      8:       return {"ADD", "_COMMENT"};
      9:       return {"GET", "_GANTT"};
      default: return "CHAT";
    endcase
  endfunction

  // Offer one byte and hold it until the transaction completes. Idle first,
  // if the phase says so, by dropping valid for a random number of cycles.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int pct;
    pct = (idle_mode == IDLE_SENDER) ? 62 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    @(negedge clk);
    if (pct != 0 && $urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < pct);
    end
    in_valid     <= 1'b1;
    in_char_byte <= b;
    in_last      <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send the assembled line, flagging its final byte, then empty the buffer.
  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      push_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // Drop valid and hold off until every owed line result has come back or the limit runs out.
  task automatic wait_drained(input int limit);
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (lines_pending != 0 && waited < limit) begin
      @(negedge clk);
      waited++;
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // One whitespace byte, half the time a plain space, else any of tab..CR.
  task automatic add_blank();
    if ($urandom_range(0, 1)) line_buf.push_back(8'd32);
    else line_buf.push_back(8'($urandom_range(9, 13)));
  endtask

  // A short word of non-whitespace bytes, mostly printable.
  task automatic add_word();
    logic [7:0] c;
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 9) < 7) begin
        c = 8'($urandom_range(33, 126));
      end else begin
        do c = 8'($urandom_range(0, 255));
        while ((c >= 8'd9 && c <= 8'd13) || c == 8'd32);
      end
      line_buf.push_back(c);
    end
  endtask

  // A command name in random letter case.
  task automatic add_keyword(input int k);
    string      s;
    logic [7:0] c;
    s = keyword_text(k);
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= 8'h41 && c <= 8'h5a && $urandom_range(0, 1)) c = c | 8'h20;
      line_buf.push_back(c);
    end
  endtask

  // Mostly well-formed command lines with random arguments; the rest is noise.
  task automatic build_random_line();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      repeat ($urandom_range(1, 24)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_blank();
      if (kind < 30) begin
        add_word();
      end else begin
        add_keyword($urandom_range(0, cll_pkg::NUM_KW - 1));
        // near misses: one letter short or one too many
        case ($urandom_range(0, 9))
          0:       void'(line_buf.pop_back());
          1:       line_buf.push_back(8'($urandom_range(65, 90)));
          default: ;
        endcase
      end
      repeat ($urandom_range(0, 6)) begin
        repeat ($urandom_range(1, 3)) add_blank();
        add_word();
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_blank();
    end
  endtask

  initial begin
    int random_bytes;
    int lines_sent;

    // Hold reset, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed lines ----
    // Blank lines: a single space, then every whitespace byte in a row.
    add_text(" ");
    send_line();
    for (int b = 9; b <= 13; b++) line_buf.push_back(8'(b));
    line_buf.push_back(8'd32);
    send_line();
    // The dispatched commands, case folded, with and without both arguments.
    add_text("ping");
    send_line();
    add_text("HeLp");
    send_line();
    add_text("register alice pw");
    send_line();
    add_text("REGISTER");
    send_line();
    add_text("LOGIN bob");
    send_line();
    // All three arguments and trailing text, mixed separators.
    add_text(" login  x");
    line_buf.push_back(8'd9);
    add_text("y z w tail end ");
    send_line();
    // Known commands that get the unknown reply.
    for (int k = 4; k < cll_pkg::NUM_KW; k++) begin
      add_keyword(k);
      add_text(" arg");
      send_line();
    end
    // First word too long, a prefix, and one letter too many.
    add_text("UPDATE_TASK_STATUSX");
    send_line();
    add_text("REGIST a b");
    send_line();
    add_text("PINGS");
    send_line();
    // Zero bytes and non-ASCII bytes are ordinary word bytes.
    add_text("PI");
    line_buf.push_back(8'h00);
    add_text("G");
    send_line();
    line_buf.push_back(8'h00);
    add_text(" a ");
    line_buf.push_back(8'hff);
    line_buf.push_back(8'd32);
    line_buf.push_back(8'h80);
    send_line();
    add_text("p");
    line_buf.push_back(8'he9);
    add_text("ng");
    send_line();

    // Pause the sender until every directed result is back.
    wait_drained(DRAIN_LIMIT);

    // ---- Random lines, in phases of idling ----
    random_bytes = 0;
    lines_sent   = 0;
    while (random_bytes < RANDOM_BYTES) begin
      if (lines_sent % 8 == 0) begin
        if (lines_sent == 64) wait_drained(DRAIN_LIMIT);
        idle_mode = idle_mode_t'($urandom_range(0, 3));
      end
      build_random_line();
      random_bytes += line_buf.size();
      send_line();
      lines_sent++;
    end

    // Drain, let the pipeline settle, then give the verdict.
    wait_drained(DRAIN_LIMIT);
    repeat (8) @(posedge clk);
    if (error_count == 0 && lines_pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cll_pkg.sv
hw/rtl/cll_front.sv
hw/rtl/cll_queue.sv
hw/rtl/cll_back.sv
hw/rtl/command_line_lexer_core.sv
verif/cll_checker.sv
verif/tb_command_line_lexer_core.sv
